// File: src/esort_pkg.sv
// Shared constants for the exchange sort engine.
package esort_pkg;

  // Width of one key (unsigned Q8.8 score).
  localparam int KEY_W = 16;

  // Default capacity of the key store.
  localparam int MAX_KEYS_DEF = 16;

endpackage

// File: src/esort_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module esort_ram #(
  parameter int WIDTH = esort_pkg::KEY_W,
  parameter int DEPTH = esort_pkg::MAX_KEYS_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] wa,
  input  logic [WIDTH-1:0]         wd,
  input  logic [$clog2(DEPTH)-1:0] ra,
  output logic [WIDTH-1:0]         rd
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd <= mem[ra];
  end

endmodule

// File: src/exchange_sort_engine.sv
// Exchange sort engine top level: key loader, sort sequencer and output register.
// Key beats are accepted while loading; the block is not ready while it sorts and emits.
// After the last key beat, S_START issues the first read, and each position i then settles
// in a sweep over the later entries, paced by the one compare per cycle of the store's
// single read port. The first key leaves once position 0 has settled.
// Reset (rst, synchronous) empties the store and drops any beat held in the output register.
module exchange_sort_engine #(
  parameter int MAX_KEYS = esort_pkg::MAX_KEYS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  // Input stream.
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [esort_pkg::KEY_W-1:0] s_tdata,   // [15:0] key_in
  input  logic                       s_tlast,   // load_last
  // Output stream.
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [esort_pkg::KEY_W-1:0] m_tdata,   // [15:0] key_out
  output logic                       m_tlast    // emit_last
);

  import esort_pkg::*;

  localparam int ADDR_W = $clog2(MAX_KEYS);
  localparam int CNT_W  = $clog2(MAX_KEYS + 1);

  // The sequencer walks position i through the store. For each i it holds the
  // running minimum in ki and streams every later entry j past the shared
  // comparator, one per cycle. When the stored entry is smaller, ki goes back
  // into slot j and the smaller key becomes the new running minimum. At the end
  // of the sweep ki is the final key for position i, so it is emitted directly
  // and never written back: no later sweep reads position i again.
  typedef enum logic [2:0] {
    S_LOAD,   // accepting key beats
    S_START,  // read issued for the first position
    S_LOADI,  // key at position i arrives from the store
    S_INNER,  // compare and swap against later entries
    S_EMIT    // hand the settled key to the output register
  } state_t;

  state_t              state;
  logic [CNT_W-1:0]    count;    // keys held; set size during a sort
  logic [ADDR_W-1:0]   i;        // position being settled
  logic [CNT_W-1:0]    j;        // next entry to read
  logic [ADDR_W-1:0]   cmp_j;    // entry whose data is on the read port
  logic                cmp_vld;  // read port carries an entry to compare
  logic [KEY_W-1:0]    ki;       // running minimum for position i

  logic                ram_we;
  logic [ADDR_W-1:0]   ram_wa;
  logic [KEY_W-1:0]    ram_wd;
  logic [ADDR_W-1:0]   ram_ra;
  logic [KEY_W-1:0]    ram_rd;

  logic                in_beat;
  logic                has_room;
  logic                issue;
  logic                swap;
  logic                emit_free;
  logic                i_last;

  assign s_tready  = (state == S_LOAD);
  assign in_beat   = s_tvalid && s_tready;
  assign has_room  = (count < CNT_W'(MAX_KEYS));
  assign issue     = (j < count);
  assign swap      = (state == S_INNER) && cmp_vld && (ki > ram_rd);
  assign emit_free = !m_tvalid || m_tready;
  assign i_last    = ((CNT_W'(i) + CNT_W'(1)) == count);

  // Store port control.
  always_comb begin
    ram_we = 1'b0;
    ram_wa = cmp_j;
    ram_wd = ki;
    ram_ra = '0;
    unique case (state)
      S_LOAD: begin
        if (in_beat && has_room) begin
          ram_we = 1'b1;
          ram_wa = count[ADDR_W-1:0];
          ram_wd = s_tdata;
        end
      end
      S_START: begin
        ram_ra = i;
      end
      S_LOADI: begin
        ram_ra = j[ADDR_W-1:0];
      end
      S_INNER: begin
        ram_ra = j[ADDR_W-1:0];
        ram_we = swap;
      end
      S_EMIT: begin
        ram_ra = i + ADDR_W'(1);
      end
      default: begin
        ram_ra = '0;
      end
    endcase
  end

  // Sequencer state and the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_LOAD;
      count    <= '0;
      i        <= '0;
      j        <= '0;
      cmp_vld  <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      // A beat taken downstream empties the register unless a new key is
      // loaded into it in the same cycle.
      if (m_tvalid && m_tready && (state != S_EMIT)) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_LOAD: begin
          if (in_beat) begin
            // A key that finds the store full is dropped.
            if (has_room) begin
              count <= count + CNT_W'(1);
            end
            if (s_tlast) begin
              i     <= '0;
              state <= S_START;
            end
          end
        end
        S_START: begin
          j     <= CNT_W'(i) + CNT_W'(1);
          state <= S_LOADI;
        end
        S_LOADI: begin
          ki <= ram_rd;
          if (issue) begin
            cmp_vld <= 1'b1;
            cmp_j   <= j[ADDR_W-1:0];
            j       <= j + CNT_W'(1);
          end else begin
            cmp_vld <= 1'b0;
          end
          state <= S_INNER;
        end
        S_INNER: begin
          if (swap) begin
            ki <= ram_rd;
          end
          if (issue) begin
            cmp_vld <= 1'b1;
            cmp_j   <= j[ADDR_W-1:0];
            j       <= j + CNT_W'(1);
          end else begin
            cmp_vld <= 1'b0;
          end
          if (!cmp_vld && !issue) begin
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (emit_free) begin
            m_tvalid <= 1'b1;
            m_tdata  <= ki;
            m_tlast  <= i_last;
            if (i_last) begin
              count <= '0;
              state <= S_LOAD;
            end else begin
              // The read for the next position is issued in this cycle.
              i     <= i + ADDR_W'(1);
              j     <= CNT_W'(i) + CNT_W'(2);
              state <= S_LOADI;
            end
          end
        end
        default: begin
          state <= S_LOAD;
        end
      endcase
    end
  end

  esort_ram #(
    .WIDTH (KEY_W),
    .DEPTH (MAX_KEYS)
  ) u_store (
    .clk (clk),
    .we  (ram_we),
    .wa  (ram_wa),
    .wd  (ram_wd),
    .ra  (ram_ra),
    .rd  (ram_rd)
  );

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_KEYS))
    else $error("key count exceeds store capacity");

  a_sort_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state != S_LOAD) |-> (count != '0))
    else $error("sort running on an empty set");

  a_cmp_in_inner: assert property (@(posedge clk) disable iff (rst)
    cmp_vld |-> (state == S_INNER))
    else $error("compare pending outside the inner sweep");

  a_swap_addr: assert property (@(posedge clk) disable iff (rst)
    swap |-> (ram_wa != ram_ra) && (cmp_j > i))
    else $error("swap write collides with the read or the settled position");

  a_swap_lowers: assert property (@(posedge clk) disable iff (rst)
    swap |=> (ki < $past(ki)))
    else $error("swap did not lower the running minimum");
`endif

endmodule
